>>> design/mtwt_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and codes for the timestamp watermark table.
package mtwt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int STAMP_W     = 48;
    localparam int SITE_W      = 16;
    localparam int TXN_W       = 64;
    localparam int DRIFT_W     = 32;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = 3;
    localparam int ACT_W       = 2;
    localparam int STAT_W      = 2;

    localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

    // Register index, taken from paddr[2]
    localparam logic REG_SITE  = 1'b0;
    localparam logic REG_DRIFT = 1'b1;

    typedef enum logic [ACT_W-1:0] {
        ACT_CREATE = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_QUERY  = 2'd2
    } act_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_MISMATCH  = 2'd2,
        ST_FULL      = 2'd3
    } stat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_RAISE,
        S_LAUNCH,
        S_WALK,
        S_APPLY
    } state_t;

    // Search key broadcast to every cell during a walk
    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic [SITE_W-1:0]  site;
        logic [TXN_W-1:0]   txn;
    } key_t;

    // Token that travels down the cell row, one cell per cycle
    typedef struct packed {
        logic               valid;
        logic               match_found;
        logic [IDX_W-1:0]   match_idx;
        logic               match_txn_eq;
        logic               free_found;
        logic [IDX_W-1:0]   free_idx;
        logic               min_found;
        logic [STAMP_W-1:0] min_stamp;
        logic [SITE_W-1:0]  min_site;
    } token_t;

    // Table update, broadcast to all cells
    typedef struct packed {
        logic               en;
        logic               set;
        logic [IDX_W-1:0]   idx;
        logic [STAMP_W-1:0] stamp;
        logic [SITE_W-1:0]  site;
        logic [TXN_W-1:0]   txn;
    } wr_t;

    // Stamp generator controls
    typedef struct packed {
        logic ld_sum;
        logic ld_cand;
        logic commit;
    } gen_ctl_t;

endpackage

>>> design/mtwt_stamp_gen.sv
`timescale 1ns / 1ps
// Stamp generator: drift add with clamp, monotonic raise, last issued stamp.
module mtwt_stamp_gen (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mtwt_pkg::gen_ctl_t            ctl,
    input  logic [mtwt_pkg::STAMP_W-1:0]  now_ms,
    input  logic [mtwt_pkg::DRIFT_W-1:0]  drift,
    output logic [mtwt_pkg::STAMP_W-1:0]  cand
);

    localparam int SUM_W = mtwt_pkg::STAMP_W + 2;

    logic [SUM_W-1:0]              sum_w;
    logic [mtwt_pkg::STAMP_W-1:0]  clamp_reg, clamp_next;
    logic [mtwt_pkg::STAMP_W-1:0]  cand_reg, cand_next;
    logic [mtwt_pkg::STAMP_W-1:0]  last_reg;

    // Sum fits a signed SUM_W value: top bit is the sign, next bit is overflow
    assign sum_w = {2'b00, now_ms}
                 + {{(SUM_W - mtwt_pkg::DRIFT_W){drift[mtwt_pkg::DRIFT_W-1]}}, drift};

    always_comb begin
        priority if (sum_w[SUM_W-1]) begin
            clamp_next = '0;
        end else if (sum_w[SUM_W-2]) begin
            clamp_next = mtwt_pkg::STAMP_MAX;
        end else begin
            clamp_next = sum_w[mtwt_pkg::STAMP_W-1:0];
        end
    end

    always_comb begin
        if (clamp_reg <= last_reg) begin
            cand_next = (last_reg == mtwt_pkg::STAMP_MAX) ? mtwt_pkg::STAMP_MAX
                                                          : last_reg + mtwt_pkg::STAMP_W'(1);
        end else begin
            cand_next = clamp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld_sum) begin
            clamp_reg <= clamp_next;
        end
        if (ctl.ld_cand) begin
            cand_reg <= cand_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg <= '0;
        end else if (ctl.commit) begin
            last_reg <= cand_reg;
        end
    end

    assign cand = cand_reg;

endmodule

>>> design/mtwt_cell.sv
`timescale 1ns / 1ps
// One table entry plus its stage of the search token chain.
module mtwt_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [mtwt_pkg::IDX_W-1:0] cell_idx,
    input  mtwt_pkg::key_t            key,
    input  mtwt_pkg::wr_t             wr,
    input  mtwt_pkg::token_t          tok_in,
    output mtwt_pkg::token_t          tok_out
);

    logic                          valid_reg;
    logic [mtwt_pkg::STAMP_W-1:0]  stamp_reg;
    logic [mtwt_pkg::SITE_W-1:0]   site_reg;
    logic [mtwt_pkg::TXN_W-1:0]    txn_reg;
    mtwt_pkg::token_t              tok_reg, tok_next;
    logic                          hit;
    logic                          wr_here;

    assign hit     = valid_reg && (stamp_reg == key.stamp) && (site_reg == key.site);
    assign wr_here = wr.en && (wr.idx == cell_idx);

    always_comb begin
        tok_next = tok_in;
        if (!tok_in.match_found && hit) begin
            tok_next.match_found  = 1'b1;
            tok_next.match_idx    = cell_idx;
            tok_next.match_txn_eq = (txn_reg == key.txn);
        end
        if (!tok_in.free_found && !valid_reg) begin
            tok_next.free_found = 1'b1;
            tok_next.free_idx   = cell_idx;
        end
        // order by stamp, then site
        if (valid_reg && (!tok_in.min_found ||
                          ({stamp_reg, site_reg} < {tok_in.min_stamp, tok_in.min_site}))) begin
            tok_next.min_found = 1'b1;
            tok_next.min_stamp = stamp_reg;
            tok_next.min_site  = site_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            tok_reg <= tok_next;
            if (wr_here) begin
                valid_reg <= wr.set;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_here && wr.set) begin
            stamp_reg <= wr.stamp;
            site_reg  <= wr.site;
            txn_reg   <= wr.txn;
        end
    end

    assign tok_out = tok_reg;

endmodule

>>> design/monotonic_timestamp_watermark_table_top.sv
`timescale 1ns / 1ps
// Top level of the monotonic timestamp watermark table.
//
// Issues increasing 48-bit timestamps (now_ms plus a signed drift, clamped,
// raised past the last issued stamp until saturated) and keeps a table of
// outstanding (stamp, site, txn) entries. Each input word carries one action:
// create issues a stamp and stores it if a slot is free, remove deletes a
// matching entry after a txn check, query returns the smallest outstanding
// (stamp, site) or a fresh stamp when the table is empty. Exactly one result
// word per input word. The table is a row of TABLE_DEPTH cells; a search
// token walks the row one cell per clock, collecting the key match, the
// lowest free slot and the minimum. One item is in flight at a time and
// passes through accept, drift add, raise, launch, the walk along the row
// and apply; apply waits until the output register is free. The result sits
// in an output register, so a new word can be taken while it waits for
// m_ready. Config registers (site at 0x0, drift at 0x4) should be written
// only while the block is idle. No clearing pass after reset.
module monotonic_timestamp_watermark_table_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // config port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mtwt_pkg::ADDR_W-1:0]     paddr,
    input  logic [mtwt_pkg::DATA_W-1:0]     pwdata,
    output logic [mtwt_pkg::DATA_W-1:0]     prdata,
    output logic                            pready,
    // input word
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [mtwt_pkg::ACT_W-1:0]      s_action,
    input  logic [mtwt_pkg::STAMP_W-1:0]    s_now_ms,
    input  logic [mtwt_pkg::TXN_W-1:0]      s_txn_ident,
    input  logic [mtwt_pkg::STAMP_W-1:0]    s_remove_stamp,
    input  logic [mtwt_pkg::SITE_W-1:0]     s_remove_site,
    // result word
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [mtwt_pkg::STAMP_W-1:0]    m_stamp_value,
    output logic [mtwt_pkg::SITE_W-1:0]     m_stamp_site,
    output logic [mtwt_pkg::STAT_W-1:0]     m_status
);

    // ---------------- config registers ----------------
    logic [mtwt_pkg::SITE_W-1:0]   site_id_reg;
    logic [mtwt_pkg::DRIFT_W-1:0]  drift_reg;
    logic                          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            site_id_reg <= '0;
            drift_reg   <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                mtwt_pkg::REG_SITE:  site_id_reg <= pwdata[mtwt_pkg::SITE_W-1:0];
                mtwt_pkg::REG_DRIFT: drift_reg   <= pwdata[mtwt_pkg::DRIFT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            mtwt_pkg::REG_SITE:  prdata = {{(mtwt_pkg::DATA_W - mtwt_pkg::SITE_W){1'b0}},
                                           site_id_reg};
            mtwt_pkg::REG_DRIFT: prdata = drift_reg;
            default:             prdata = '0;
        endcase
    end

    // ---------------- control ----------------
    mtwt_pkg::state_t    state_reg, state_next;
    mtwt_pkg::gen_ctl_t  gen_ctl;
    logic                accept;
    logic                launch;
    logic                capture;
    logic                apply_go;
    logic                out_free;
    logic                commit;

    mtwt_pkg::token_t    tok_chain [0:mtwt_pkg::TABLE_DEPTH];
    mtwt_pkg::token_t    res_tok_reg;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mtwt_pkg::S_IDLE:   if (s_valid) state_next = mtwt_pkg::S_SUM;
            mtwt_pkg::S_SUM:    state_next = mtwt_pkg::S_RAISE;
            mtwt_pkg::S_RAISE:  state_next = mtwt_pkg::S_LAUNCH;
            mtwt_pkg::S_LAUNCH: state_next = mtwt_pkg::S_WALK;
            mtwt_pkg::S_WALK: begin
                if (tok_chain[mtwt_pkg::TABLE_DEPTH].valid) state_next = mtwt_pkg::S_APPLY;
            end
            mtwt_pkg::S_APPLY:  if (out_free) state_next = mtwt_pkg::S_IDLE;
            default:            state_next = mtwt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_ready          = (state_reg == mtwt_pkg::S_IDLE);
        gen_ctl.ld_sum   = (state_reg == mtwt_pkg::S_SUM);
        gen_ctl.ld_cand  = (state_reg == mtwt_pkg::S_RAISE);
        gen_ctl.commit   = commit;
        launch           = (state_reg == mtwt_pkg::S_LAUNCH);
        capture          = (state_reg == mtwt_pkg::S_WALK) &&
                           tok_chain[mtwt_pkg::TABLE_DEPTH].valid;
        apply_go         = (state_reg == mtwt_pkg::S_APPLY) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mtwt_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------- captured input word ----------------
    mtwt_pkg::act_t                op_reg;
    logic [mtwt_pkg::STAMP_W-1:0]  now_reg;
    logic [mtwt_pkg::STAMP_W-1:0]  key_stamp_reg;
    logic [mtwt_pkg::SITE_W-1:0]   key_site_reg;
    logic [mtwt_pkg::TXN_W-1:0]    key_txn_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg        <= mtwt_pkg::act_t'(s_action);
            now_reg       <= s_now_ms;
            key_stamp_reg <= s_remove_stamp;
            key_site_reg  <= (s_action == mtwt_pkg::ACT_CREATE) ? site_id_reg : s_remove_site;
            key_txn_reg   <= s_txn_ident;
        end
        if (capture) begin
            res_tok_reg <= tok_chain[mtwt_pkg::TABLE_DEPTH];
        end
    end

    // ---------------- stamp generator ----------------
    logic [mtwt_pkg::STAMP_W-1:0] cand;

    mtwt_stamp_gen u_gen (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (gen_ctl),
        .now_ms  (now_reg),
        .drift   (drift_reg),
        .cand    (cand)
    );

    // ---------------- cell row ----------------
    mtwt_pkg::key_t key;
    mtwt_pkg::wr_t  wr;

    // create searches for its own fresh stamp (duplicate key once saturated)
    assign key.stamp = (op_reg == mtwt_pkg::ACT_CREATE) ? cand : key_stamp_reg;
    assign key.site  = key_site_reg;
    assign key.txn   = key_txn_reg;

    always_comb begin
        tok_chain[0]       = '0;
        tok_chain[0].valid = launch;
    end

    for (genvar gi = 0; gi < mtwt_pkg::TABLE_DEPTH; gi++) begin : g_cell
        mtwt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (mtwt_pkg::IDX_W'(gi)),
            .key      (key),
            .wr       (wr),
            .tok_in   (tok_chain[gi]),
            .tok_out  (tok_chain[gi+1])
        );
    end

    // ---------------- apply: table update and result ----------------
    logic [mtwt_pkg::STAMP_W-1:0]  res_val;
    logic [mtwt_pkg::SITE_W-1:0]   res_site;
    mtwt_pkg::stat_t               res_stat;
    logic                          wr_req;
    logic                          commit_req;

    always_comb begin
        res_val    = '0;
        res_site   = '0;
        res_stat   = mtwt_pkg::ST_OK;
        wr_req     = 1'b0;
        commit_req = 1'b0;
        wr.set     = 1'b0;
        wr.idx     = res_tok_reg.match_idx;
        wr.stamp   = cand;
        wr.site    = site_id_reg;
        wr.txn     = key_txn_reg;
        case (op_reg)
            mtwt_pkg::ACT_CREATE: begin
                res_val    = cand;
                res_site   = site_id_reg;
                commit_req = 1'b1;
                wr.set     = 1'b1;
                priority if (res_tok_reg.match_found) begin
                    wr_req = 1'b1;
                end else if (res_tok_reg.free_found) begin
                    wr_req = 1'b1;
                    wr.idx = res_tok_reg.free_idx;
                end else begin
                    res_stat = mtwt_pkg::ST_FULL;
                end
            end
            mtwt_pkg::ACT_REMOVE: begin
                priority if (!res_tok_reg.match_found) begin
                    res_stat = mtwt_pkg::ST_NOT_FOUND;
                end else if (!res_tok_reg.match_txn_eq) begin
                    res_stat = mtwt_pkg::ST_MISMATCH;
                end else begin
                    wr_req = 1'b1;
                end
            end
            mtwt_pkg::ACT_QUERY: begin
                if (res_tok_reg.min_found) begin
                    res_val  = res_tok_reg.min_stamp;
                    res_site = res_tok_reg.min_site;
                end else begin
                    res_val    = cand;
                    res_site   = site_id_reg;
                    commit_req = 1'b1;
                end
            end
            default: ;  // unused action: no effect, all-zero result
        endcase
        wr.en  = apply_go && wr_req;
        commit = apply_go && commit_req;
    end

    // ---------------- output register ----------------
    logic                          m_valid_reg, m_valid_next;
    logic [mtwt_pkg::STAMP_W-1:0]  m_stamp_value_reg;
    logic [mtwt_pkg::SITE_W-1:0]   m_stamp_site_reg;
    mtwt_pkg::stat_t               m_status_reg;

    always_comb begin
        priority if (apply_go) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (apply_go) begin
            m_stamp_value_reg <= res_val;
            m_stamp_site_reg  <= res_site;
            m_status_reg      <= res_stat;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_stamp_value = m_stamp_value_reg;
    assign m_stamp_site  = m_stamp_site_reg;
    assign m_status      = m_status_reg;

endmodule

>>> design/mtwt_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the timestamp watermark table, bound to the top level.
module mtwt_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [mtwt_pkg::STAMP_W-1:0]    m_stamp_value,
    input logic [mtwt_pkg::SITE_W-1:0]     m_stamp_site,
    input logic [mtwt_pkg::STAT_W-1:0]     m_status
);

    // one word in flight: input closes right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a word is in flight");

    // remove failures return a zero stamp and site
    a_remove_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == mtwt_pkg::ST_NOT_FOUND ||
                     m_status == mtwt_pkg::ST_MISMATCH))
        |-> (m_stamp_value == '0 && m_stamp_site == '0))
        else $error("remove failure with nonzero stamp");

    // out of reset: idle, ready, no result
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("block not idle after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_stamp_value) &&
                                   $stable(m_stamp_site) && $stable(m_status)))
        else $error("result changed while stalled");

endmodule

bind monotonic_timestamp_watermark_table_top mtwt_checker u_mtwt_checker (.*);
